// ----- rtl/spk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, constants and a word rotate helper for the Speck48/96 cipher core.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int WordW      = 24;
  localparam int SchedSteps = 22;
  localparam int Rounds     = 23;

  typedef logic [WordW-1:0] word_t;

  // operation codes carried in tuser
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // one request in flight: block words plus its own copy of the key schedule
  typedef struct packed {
    logic  kind;
    word_t x;
    word_t y;
    word_t k;
    word_t l0;
    word_t l1;
    word_t l2;
  } spk_item_t;

  function automatic word_t rol(input word_t v, input int unsigned n);
    rol = (v << n) | (v >> (WordW - n));
  endfunction

endpackage

// ----- rtl/spk_fwd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_fwd_cell
// Forward cell: one key schedule step, plus one encryption round when the
// request is an encrypt.
// ----------------------------------------------------------------------------
module spk_fwd_cell
  import spk_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  spk_item_t in_item,
  output logic      out_valid,
  output spk_item_t out_item
);

  word_t     fresh;
  word_t     rx;
  spk_item_t item_next;

  always_comb begin
    fresh = (rol(in_item.l0, 16) + in_item.k) ^ word_t'(STEP);
    rx    = (rol(in_item.x, 16) + in_item.y) ^ in_item.k;

    item_next    = in_item;
    item_next.k  = rol(in_item.k, 3) ^ fresh;
    item_next.l0 = in_item.l1;
    item_next.l1 = in_item.l2;
    item_next.l2 = fresh;
    if (in_item.kind == KIND_ENC) begin
      item_next.x = rx;
      item_next.y = rol(in_item.y, 3) ^ rx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/spk_rev_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_rev_cell
// Reverse cell: for a decrypt request, one decryption round with the current round key; then,
// except in the last cell, one key schedule step undone. The first cell also runs the last encrypt round.
// ----------------------------------------------------------------------------
module spk_rev_cell
  import spk_pkg::*;
#(
  parameter int STEP  = 0,
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  spk_item_t in_item,
  output logic      out_valid,
  output spk_item_t out_item
);

  word_t     ex;
  word_t     dy;
  word_t     k_prev;
  spk_item_t item_next;

  always_comb begin
    ex     = (rol(in_item.x, 16) + in_item.y) ^ in_item.k;
    dy     = rol(in_item.y ^ in_item.x, 21);
    k_prev = rol(in_item.k ^ in_item.l2, 21);

    item_next = in_item;
    if (in_item.kind == KIND_DEC) begin
      item_next.y = dy;
      item_next.x = rol((in_item.x ^ in_item.k) - dy, 8);
    end else if (FIRST) begin
      item_next.x = ex;
      item_next.y = rol(in_item.y, 3) ^ ex;
    end

    // undo schedule step: l2 holds the word that step produced
    if (!LAST) begin
      item_next.k  = k_prev;
      item_next.l0 = rol((in_item.l2 ^ word_t'(STEP)) - k_prev, 8);
      item_next.l1 = in_item.l0;
      item_next.l2 = in_item.l1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/speck48_96_block_cipher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck48_96_block_cipher_core
// Speck48/96 encrypt/decrypt core built as a chain of pipelined cells.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | tuser: kind, tdata: block
//  m_axis   | out       | m_axis_tvalid/tready       | tdata: result block
//  cfg      | in        | cfg_we (no wait)           | cfg_index, cfg_data
//
// One request per cycle while the chain is not held; each request passes 22 forward
// cells, then 23 reverse cells, one register each.
// Every request carries its own copy of the key schedule, so a key written
// just before a request is used by it.
// A result not taken holds the whole chain; the input stalls with it.
// Synchronous reset clears the valid bits and key words to zero.
// ----------------------------------------------------------------------------
module speck48_96_block_cipher_core
  import spk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] block_low, [47:24] block_high
  input  logic [0:0]  s_axis_tuser,   // [0] kind (0 encrypt, 1 decrypt)
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] result_low, [47:24] result_high
  // key configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int NCells = SchedSteps + Rounds;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  word_t key_word_0;
  word_t key_word_1;
  word_t key_word_2;
  word_t key_word_3;

  logic      en;
  logic      valid [NCells+1];
  spk_item_t item  [NCells+1];

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY0: key_word_0 <= cfg_data;
        REG_KEY1: key_word_1 <= cfg_data;
        REG_KEY2: key_word_2 <= cfg_data;
        REG_KEY3: key_word_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole chain moves unless the final result is held
  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  // request entering the chain, with the key snapshot
  always_comb begin
    valid[0]      = s_axis_tvalid;
    item[0].kind  = s_axis_tuser[0];
    item[0].x     = s_axis_tdata[23:0];
    item[0].y     = s_axis_tdata[47:24];
    item[0].k     = key_word_0;
    item[0].l0    = key_word_1;
    item[0].l1    = key_word_2;
    item[0].l2    = key_word_3;
  end

  // forward cells: schedule steps 0..21, encrypt rounds 0..21
  for (genvar i = 0; i < SchedSteps; i++) begin : g_fwd
    spk_fwd_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid[i]),
      .in_item  (item[i]),
      .out_valid(valid[i+1]),
      .out_item (item[i+1])
    );
  end

  // reverse cells: decrypt with keys 22 down to 0, undoing steps 21..0;
  // the first one also does encrypt round 22
  for (genvar j = 0; j < Rounds; j++) begin : g_rev
    spk_rev_cell #(
      .STEP (SchedSteps - 1 - j),
      .FIRST(j == 0),
      .LAST (j == Rounds - 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid[SchedSteps+j]),
      .in_item  (item[SchedSteps+j]),
      .out_valid(valid[SchedSteps+j+1]),
      .out_item (item[SchedSteps+j+1])
    );
  end

  assign m_axis_tvalid = valid[NCells];
  assign m_axis_tdata  = {item[NCells].y, item[NCells].x};

endmodule

// ----- bench/speck48_96_block_cipher_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speck48_96_block_cipher_core_tb
// Self-checking bench for the Speck48/96 core. Streams encrypt and decrypt
// requests under several key settings and random back-pressure. Every
// result is checked against a software model of the cipher that the bench
// keeps in a small scoreboard.
// ----------------------------------------------------------------------------

// Holds the key words, predicts each block, keeps the results still owed.
class speck_scoreboard;

  typedef struct {
    logic          kind;
    spk_pkg::word_t lo;
    spk_pkg::word_t hi;
  } owed_block_t;

  spk_pkg::word_t key_words[4];
  owed_block_t    owed_blocks[$];
  int             errors;

  function new();
    foreach (key_words[i]) key_words[i] = '0;
    errors = 0;
  endfunction

  function void set_key(int idx, spk_pkg::word_t val);
    key_words[idx] = val;
  endfunction

  function int pending();
    return owed_blocks.size();
  endfunction

  // rotate left via a doubled word
  function spk_pkg::word_t spin(spk_pkg::word_t v, int unsigned n);
    logic [47:0] dbl;
    dbl = {v, v} >> (24 - n);
    return dbl[23:0];
  endfunction

  // expand the key schedule and run all rounds in one direction
  function void cipher_block(logic kind, spk_pkg::word_t x_in, spk_pkg::word_t y_in,
                             output spk_pkg::word_t x_out, output spk_pkg::word_t y_out);
    spk_pkg::word_t rk[spk_pkg::Rounds];
    spk_pkg::word_t sched[spk_pkg::SchedSteps + 3];
    spk_pkg::word_t x;
    spk_pkg::word_t y;
    x = x_in;
    y = y_in;
    rk[0]    = key_words[0];
    sched[0] = key_words[1];
    sched[1] = key_words[2];
    sched[2] = key_words[3];
    for (int s = 0; s < spk_pkg::SchedSteps; s++) begin
      sched[s + 3] = (spin(sched[s], 16) + rk[s]) ^ spk_pkg::word_t'(s);
      rk[s + 1]    = spin(rk[s], 3) ^ sched[s + 3];
    end
    if (kind == spk_pkg::KIND_ENC) begin
      for (int r = 0; r < spk_pkg::Rounds; r++) begin
        x = (spin(x, 16) + y) ^ rk[r];
        y = spin(y, 3) ^ x;
      end
    end else begin
      for (int r = 0; r < spk_pkg::Rounds; r++) begin
        y = spin(y ^ x, 21);
        x = spin(spk_pkg::word_t'((x ^ rk[spk_pkg::Rounds - 1 - r]) - y), 8);
      end
    end
    x_out = x;
    y_out = y;
  endfunction

  function void note_request(logic kind, spk_pkg::word_t lo, spk_pkg::word_t hi);
    owed_block_t b;
    b.kind = kind;
    cipher_block(kind, lo, hi, b.lo, b.hi);
    owed_blocks.push_back(b);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task check_result(logic [47:0] data);
    owed_block_t b;
    if (owed_blocks.size() == 0) begin
      report($sformatf("result %h with no request pending", data));
    end else begin
      b = owed_blocks.pop_front();
      if (data[23:0] !== b.lo)
        report($sformatf("kind %0d result_low %h, want %h", b.kind, data[23:0], b.lo));
      if (data[47:24] !== b.hi)
        report($sformatf("kind %0d result_high %h, want %h", b.kind, data[47:24], b.hi));
    end
  endtask

endclass

module speck48_96_block_cipher_core_tb;
  import spk_pkg::*;

  localparam int StallLimit = 5000;  // cycles with no handshake and no key write
  localparam int TailCycles = 60;    // pipeline is 45 deep
  localparam int SegItems   = 183;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  speck_scoreboard sb = new();

  int send_idle = 6;    // percent of cycles the sender holds back
  int recv_idle = 78;   // percent of cycles the receiver holds back
  int hold_left = 0;    // long receiver hold-off, cycles
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  speck48_96_block_cipher_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // receiver: random ready, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog: any handshake or key write resets the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly random words, with the all-zero and all-one words now and then
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge; tvalid stays high for the next request
  task automatic send_request(logic kind, word_t lo, word_t hi);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, lo, hi);
    @(negedge clk);
  endtask

  // drop valid, then wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // key writes only happen with the core empty
  task automatic write_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    word_t kw[4];
    kw = '{k0, k1, k2, k3};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= kw[i];
      @(posedge clk);
      sb.set_key(i, kw[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // edge-case blocks in both directions
  task automatic run_directed(int count);
    word_t lo_list[10];
    word_t hi_list[10];
    logic  kd_list[10];
    lo_list = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h555555, 24'h800000};
    hi_list = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'h000000, 24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h000001};
    kd_list = '{KIND_ENC, KIND_DEC, KIND_ENC, KIND_DEC, KIND_ENC,
                KIND_ENC, KIND_DEC, KIND_DEC, KIND_ENC, KIND_DEC};
    for (int i = 0; i < count; i++) send_request(kd_list[i], lo_list[i], hi_list[i]);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset keys, all-ones keys, then random keys
    run_directed(4);
    write_keys('1, '1, '1, '1);
    run_directed(10);
    write_keys(word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom));
    run_directed(10);

    // random: three idle regimes, two key settings each
    for (int regime = 0; regime < 3; regime++) begin
      for (int seg = 0; seg < 2; seg++) begin
        write_keys(pick_word(), pick_word(), pick_word(), pick_word());
        case (regime)
          0: begin send_idle = 6;  recv_idle = 78; end
          1: begin send_idle = 78; recv_idle = 6;  end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        for (int n = 0; n < SegItems; n++) begin
          // fill the pipe while the output is blocked
          if (regime == 2 && seg == 0 && n == 30) hold_left = 400;
          send_request($urandom_range(1), pick_word(), pick_word());
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
